// File: hdl/ipte_pkg.sv
// ipte_pkg: constants and types shared by the IPv4/TCP payload extractor.
// No dependencies.
package ipte_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 16;   // byte index within a packet
    localparam int unsigned LEN_W       = 16;   // IPv4 total length
    localparam int unsigned HDR_W       = 6;    // one header length, bytes (max 60)
    localparam int unsigned HDR_END_W   = 7;    // sum of both headers (max 120)

    localparam int unsigned NIBBLE_MASK     = 15;  // IHL / data offset field mask
    localparam int unsigned WORD_BYTES      = 4;   // header lengths count 32-bit words
    localparam int unsigned OFFSET_BYTE_IDX = 12;  // data offset byte within TCP header
    localparam int unsigned MIN_TOTAL_LEN   = 4;   // shorter totals are raised to this

    // Fixed byte positions of the IPv4 header fields used here
    localparam logic [POS_W-1:0] POS_IHL    = 16'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI = 16'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO = 16'd3;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        byte_t payload_byte;
        logic  last_of_packet;
        logic  malformed;
    } result_t;

endpackage

// File: hdl/ipte_byte_if.sv
// ipte_byte_if: valid/ready channel carrying one raw stream byte per transaction.
// Depends on ipte_pkg.
interface ipte_byte_if;
    import ipte_pkg::*;

    logic  valid;
    logic  ready;
    byte_t stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// File: hdl/ipte_result_if.sv
// ipte_result_if: valid/ready channel carrying one extracted payload result.
// Depends on ipte_pkg.
interface ipte_result_if;
    import ipte_pkg::*;

    logic  valid;
    logic  ready;
    byte_t payload_byte;
    logic  last_of_packet;
    logic  malformed;

    modport source (output valid, output payload_byte, output last_of_packet,
                    output malformed, input ready);
    modport sink   (input valid, input payload_byte, input last_of_packet,
                    input malformed, output ready);
endinterface

// File: hdl/ipv4_tcp_payload_extractor.sv
// ipv4_tcp_payload_extractor: strips IPv4 and TCP headers from a byte stream.
// Depends on ipte_pkg, ipte_byte_if, ipte_result_if.
//
// Usage:
//  packet_stream  - sink channel, one raw byte of back-to-back IPv4/TCP
//                   packets per transaction. Packet boundaries come from the
//                   IPv4 total length field; there is no framing signal.
//  payload_stream - source channel, one result per TCP payload byte. The
//                   last payload byte of a packet has last_of_packet set.
//                   A packet that ends before both headers are complete gives
//                   a single result with malformed and last_of_packet set and
//                   payload_byte zero. Header bytes produce no transaction.
//  Path: input register -> parser -> result register; a byte in the input
//  register is parsed and any result it gives is written to the result register.
//  Throughput: one byte per cycle sustained while payload_stream is not stalled;
//  the parse is a counter, a few narrow adds and compares, all combinational.
//  Stalls: when payload_stream is stalled and the result register is full,
//  the parser holds a byte that would produce a result, and packet_stream
//  ready drops once the input register is also occupied. Header bytes keep
//  flowing through the parser since they produce nothing.
//  Reset: rst_n (async, active low) empties both registers and returns the
//  parser to the start of a packet.
module ipv4_tcp_payload_extractor
(
    input  logic          clk,
    input  logic          rst_n,
    ipte_byte_if.sink     packet_stream,
    ipte_result_if.source payload_stream
);
    import ipte_pkg::*;

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;

    // parser state
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [LEN_W-1:0] len_reg,  len_next;
    logic [HDR_W-1:0] ip_reg,   ip_next;
    logic [HDR_W-1:0] tcp_reg,  tcp_next;
    logic             seen_reg, seen_next;

    // result register
    logic    out_valid_reg;
    result_t out_reg, out_next;

    // parse of the byte in the input register
    logic [LEN_W-1:0]     len_lo;
    logic [LEN_W-1:0]     len_eff;
    logic [HDR_W-1:0]     ip_eff;
    logic [HDR_W-1:0]     tcp_eff;
    logic                 seen_eff;
    logic                 tcp_hit;
    logic [HDR_END_W-1:0] end_full;
    logic [HDR_END_W-1:0] end_min;
    logic [HDR_END_W-1:0] hdr_end;
    logic                 is_payload;
    logic                 is_end;
    logic                 complete;
    logic                 emit;
    logic                 out_free;
    logic                 advance;

    always_comb
    begin
        // IHL is taken from byte 0 and used in the same cycle
        ip_eff = (pos_reg == POS_IHL)
               ? HDR_W'(in_byte_reg[3:0] & 4'(NIBBLE_MASK)) * HDR_W'(WORD_BYTES)
               : ip_reg;

        // total length: high byte at 2, low byte at 3 with a floor of four
        len_lo = {len_reg[LEN_W-1:BYTE_W], in_byte_reg};
        if (pos_reg == POS_LEN_HI)
        begin
            len_eff = {in_byte_reg, BYTE_W'(0)};
        end
        else if (pos_reg == POS_LEN_LO)
        begin
            len_eff = (len_lo < LEN_W'(MIN_TOTAL_LEN)) ? LEN_W'(MIN_TOTAL_LEN) : len_lo;
        end
        else
        begin
            len_eff = len_reg;
        end

        // TCP data offset byte
        tcp_hit  = !seen_reg
                && ({1'b0, pos_reg} == (17'(ip_eff) + 17'(OFFSET_BYTE_IDX)));
        tcp_eff  = tcp_hit
                 ? HDR_W'(in_byte_reg[7:4] & 4'(NIBBLE_MASK)) * HDR_W'(WORD_BYTES)
                 : tcp_reg;
        seen_eff = seen_reg | tcp_hit;

        // headers never end at or before the data offset byte
        end_full = HDR_END_W'(ip_eff) + HDR_END_W'(tcp_eff);
        end_min  = HDR_END_W'(ip_eff) + HDR_END_W'(OFFSET_BYTE_IDX + 1);
        hdr_end  = (end_full > end_min) ? end_full : end_min;

        is_payload = !tcp_hit && seen_reg && (pos_reg >= POS_W'(hdr_end));
        is_end     = (pos_reg >= POS_LEN_LO)
                  && ((17'(pos_reg) + 17'd1) == {1'b0, len_eff});
        complete   = seen_eff && (LEN_W'(hdr_end) <= len_eff);
        emit       = is_payload || (is_end && !complete);

        if (is_payload)
        begin
            out_next.payload_byte   = in_byte_reg;
            out_next.last_of_packet = is_end;
            out_next.malformed      = 1'b0;
        end
        else
        begin
            out_next.payload_byte   = '0;
            out_next.last_of_packet = 1'b1;
            out_next.malformed      = 1'b1;
        end

        // handshake
        out_free = !out_valid_reg || payload_stream.ready;
        advance  = in_valid_reg && (!emit || out_free);

        // next parser state; the end of a packet restarts everything
        if (is_end)
        begin
            pos_next  = '0;
            len_next  = '0;
            ip_next   = '0;
            tcp_next  = '0;
            seen_next = 1'b0;
        end
        else
        begin
            pos_next  = pos_reg + POS_W'(1);
            len_next  = len_eff;
            ip_next   = ip_eff;
            tcp_next  = tcp_eff;
            seen_next = seen_eff;
        end
    end

    assign packet_stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (packet_stream.ready)
        begin
            in_valid_reg <= packet_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet_stream.ready && packet_stream.valid)
        begin
            in_byte_reg <= packet_stream.stream_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            ip_reg   <= '0;
            tcp_reg  <= '0;
            seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            ip_reg   <= ip_next;
            tcp_reg  <= tcp_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign payload_stream.valid          = out_valid_reg;
    assign payload_stream.payload_byte   = out_reg.payload_byte;
    assign payload_stream.last_of_packet = out_reg.last_of_packet;
    assign payload_stream.malformed      = out_reg.malformed;

    // a malformed result is always a zero byte that closes its packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.malformed)
        |-> (out_reg.last_of_packet && (out_reg.payload_byte == '0)))
        else $error("malformed result without zero byte and packet end");

    // parsing a packet's last byte returns the parser to packet start
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_end) |=> ((pos_reg == '0) && !seen_reg && (len_reg == '0)))
        else $error("parser not restarted after end of packet");

    // the data offset byte lies behind the current position once seen
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> ({1'b0, pos_reg} > (17'(ip_reg) + 17'(OFFSET_BYTE_IDX))))
        else $error("data offset flag set ahead of its byte");

    // a byte that would produce a result never leaves the input register
    // while the result register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && emit && out_valid_reg && !payload_stream.ready)
        |=> (in_valid_reg && $stable(pos_reg)))
        else $error("result dropped under backpressure");

endmodule
